// ===== hw/rtl/flc_pkg.sv =====
// Shared constants and types for the full linear convolution block.
// Used by full_linear_convolution, its checkers and the testbench; no dependencies.
`timescale 1ns / 1ps

package flc_pkg;

   // Sizes
   localparam int MAX_TAPS    = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = $clog2(MAX_TAPS);
   localparam int LEN_BITS    = $clog2(MAX_TAPS + 1);
   localparam int PROD_BITS   = 2 * SAMPLE_BITS;
   localparam int CONV_BITS   = 38;
   localparam int CFG_BITS    = 7;
   localparam int TAP_BITS    = 6;

   // Stream payload sizes (padded to whole bytes)
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 40;

   // CSR map: register index taken from paddr[2]
   localparam int  CSR_ADDR_BITS      = 3;
   localparam logic REG_KERNEL_LENGTH = 1'b0;

   // Item kinds carried on req_tuser
   localparam logic OP_KERNEL = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN
   } state_type;

endpackage

// ===== hw/rtl/full_linear_convolution.sv =====
// Full linear convolution: kernel and delay-line memories, one shared MAC.
// Depends on flc_pkg.
`timescale 1ns / 1ps

// Kernel transfers (req_tuser = 0) write one tap and leave the input ready.
// A sample transfer (req_tuser = 1) shifts the sample into a circular delay
// line and walks the kernel with one multiply-accumulate per tap, through the
// single read port of each memory and the read / multiply / accumulate
// pipeline. A sample with tlast set also produces kernel_length - 1 tail
// results, each from its own tap walk; the final one carries rsp_tlast and
// the delay line then reads as zeros again (per-entry valid bits, cleared
// together, no clearing pass). The result register decouples the output: a
// new transfer is taken while a result waits. Taps never written read as
// undefined data.
module full_linear_convolution (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [5:0] tap_index, [21:6] sample_value, [23:22] zero
   input  logic        req_tuser,   // op
   input  logic        req_tlast,   // is_last
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [37:0] conv_value, [39:38] zero
   output logic        rsp_tlast,   // last_out
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = flc_pkg::ADDR_BITS;
   localparam int SW = flc_pkg::SAMPLE_BITS;

   // Memories
   logic signed [SW-1:0] kmem [flc_pkg::MAX_TAPS];
   logic signed [SW-1:0] hmem [flc_pkg::MAX_TAPS];

   // Control state
   flc_pkg::state_type            state_ff, state_in;
   logic [AW-1:0]                 j_ff, j_in;
   logic [AW-1:0]                 wp_ff, wp_in;
   logic [AW-1:0]                 cnt_ff, cnt_in;
   logic [flc_pkg::LEN_BITS-1:0]  len_ff, len_in;
   logic                          last_ff, last_in;
   logic [flc_pkg::MAX_TAPS-1:0]  hvalid_ff, hvalid_in;
   logic [flc_pkg::CFG_BITS-1:0]  kernel_length_ff, kernel_length_in;

   // Pipeline
   logic                              p1_ff, p2_ff;
   logic signed [SW-1:0]              kdata_ff, hdata_ff;
   logic                              hvld_ff;
   logic signed [flc_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [flc_pkg::CONV_BITS-1:0] acc_ff, acc_in;
   logic                              acc_clr;

   // Output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [flc_pkg::CONV_BITS-1:0]     rsp_data_ff;
   logic                              rsp_last_ff;
   logic                              rsp_load, rsp_last_set;

   // Memory write controls
   logic                 kw_en, hw_en;
   logic [AW-1:0]        hw_addr;
   logic signed [SW-1:0] hw_data;

   logic                 req_xfer, csr_wr;
   logic [AW-1:0]        hist_raddr, last_idx;
   logic [flc_pkg::LEN_BITS-1:0] len_eff;
   logic [flc_pkg::TAP_BITS-1:0]  req_tap_index;
   logic signed [SW-1:0] req_sample_value;
   logic signed [SW-1:0] hsamp;

   assign req_tap_index    = req_tdata[flc_pkg::TAP_BITS-1:0];
   assign req_sample_value = req_tdata[flc_pkg::TAP_BITS +: SW];
   assign req_tready       = (state_ff == flc_pkg::ST_IDLE);
   assign req_xfer         = req_tvalid & req_tready;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == flc_pkg::REG_KERNEL_LENGTH) ?
                       32'(kernel_length_ff) : '0;

   always_comb begin
      kernel_length_in = kernel_length_ff;
      if (csr_wr && csr_paddr[2] == flc_pkg::REG_KERNEL_LENGTH) begin
         kernel_length_in = csr_pwdata[flc_pkg::CFG_BITS-1:0];
      end
   end

   // Effective tap count: zero reads as one, large values saturate
   always_comb begin
      if (kernel_length_ff == '0) begin
         len_eff = flc_pkg::LEN_BITS'(1);
      end else if (int'(kernel_length_ff) > flc_pkg::MAX_TAPS) begin
         len_eff = flc_pkg::LEN_BITS'(flc_pkg::MAX_TAPS);
      end else begin
         len_eff = flc_pkg::LEN_BITS'(kernel_length_ff);
      end
   end

   assign last_idx   = AW'(len_ff - flc_pkg::LEN_BITS'(1));
   assign hist_raddr = wp_ff - j_ff;

   // Sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      last_in      = last_ff;
      hvalid_in    = hvalid_ff;
      acc_clr      = 1'b0;
      rsp_load     = 1'b0;
      rsp_last_set = 1'b0;
      kw_en        = 1'b0;
      hw_en        = 1'b0;
      hw_addr      = wp_ff + AW'(1);
      hw_data      = req_sample_value;
      case (state_ff)
         flc_pkg::ST_IDLE: begin
            if (req_xfer && req_tuser == flc_pkg::OP_KERNEL) begin
               kw_en = (int'(req_tap_index) < flc_pkg::MAX_TAPS);
            end else if (req_xfer) begin
               // push the sample and start the tap walk
               hw_en              = 1'b1;
               hvalid_in[hw_addr] = 1'b1;
               wp_in              = hw_addr;
               len_in             = len_eff;
               last_in            = req_tlast;
               cnt_in             = '0;
               j_in               = '0;
               acc_clr            = 1'b1;
               state_in           = flc_pkg::ST_MAC;
            end
         end
         flc_pkg::ST_MAC: begin
            j_in = j_ff + AW'(1);
            if (j_ff == last_idx) begin
               state_in = flc_pkg::ST_DRAIN;
            end
         end
         flc_pkg::ST_DRAIN: begin
            // wait for the pipeline to empty and the result register to free up
            if (!p1_ff && !p2_ff && (!rsp_valid_ff || rsp_tready)) begin
               rsp_load     = 1'b1;
               rsp_last_set = last_ff && (cnt_ff == last_idx);
               if (last_ff && cnt_ff != last_idx) begin
                  // tail: shift in a zero and run again
                  hw_en              = 1'b1;
                  hw_data            = '0;
                  hvalid_in[hw_addr] = 1'b1;
                  wp_in              = hw_addr;
                  cnt_in             = cnt_ff + AW'(1);
                  j_in               = '0;
                  acc_clr            = 1'b1;
                  state_in           = flc_pkg::ST_MAC;
               end else begin
                  if (last_ff) begin
                     hvalid_in = '0;
                  end
                  state_in = flc_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = flc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= flc_pkg::ST_IDLE;
         j_ff             <= '0;
         wp_ff            <= '0;
         cnt_ff           <= '0;
         len_ff           <= flc_pkg::LEN_BITS'(1);
         last_ff          <= 1'b0;
         hvalid_ff        <= '0;
         kernel_length_ff <= flc_pkg::CFG_BITS'(1);
         p1_ff            <= 1'b0;
         p2_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         j_ff             <= j_in;
         wp_ff            <= wp_in;
         cnt_ff           <= cnt_in;
         len_ff           <= len_in;
         last_ff          <= last_in;
         hvalid_ff        <= hvalid_in;
         kernel_length_ff <= kernel_length_in;
         p1_ff            <= (state_ff == flc_pkg::ST_MAC);
         p2_ff            <= p1_ff;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Memory writes
   always_ff @(posedge clock) begin
      if (kw_en) begin
         kmem[req_tap_index[AW-1:0]] <= req_sample_value;
      end
      if (hw_en) begin
         hmem[hw_addr] <= hw_data;
      end
   end

   // Memory reads, registered
   always_ff @(posedge clock) begin
      kdata_ff <= kmem[j_ff];
      hdata_ff <= hmem[hist_raddr];
      hvld_ff  <= hvalid_ff[hist_raddr];
   end

   // Multiply, then accumulate
   assign hsamp  = hvld_ff ? hdata_ff : '0;
   assign acc_in = acc_clr ? '0 :
                   (p2_ff ? acc_ff + flc_pkg::CONV_BITS'(prod_ff) : acc_ff);

   always_ff @(posedge clock) begin
      prod_ff <= kdata_ff * hsamp;
      acc_ff  <= acc_in;
   end

   // Result register
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= acc_ff;
         rsp_last_ff <= rsp_last_set;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = flc_pkg::RSP_DATA_BITS'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/flc_checker.sv =====
// Port-level checks for full_linear_convolution, attached by bind.
// Depends on flc_pkg.
`timescale 1ns / 1ps

module flc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // no result pending right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a kernel write leaves the input ready
   a_kernel_quick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == flc_pkg::OP_KERNEL |=> req_tready)
      else $error("kernel transfer stalled the input");

   // a sample starts the tap walk and blocks the input
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == flc_pkg::OP_SAMPLE |=> !req_tready)
      else $error("input ready during tap walk");

endmodule

bind full_linear_convolution flc_checker u_flc_checker (.*);

// ===== bench/flc_conv_checker.sv =====
// Checker for full_linear_convolution: watches the stream and CSR ports, predicts every result.
// Depends on flc_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module flc_conv_checker
   import flc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [5:0] tap_index, [21:6] sample_value, [23:22] zero
   input  logic        req_tuser,   // op
   input  logic        req_tlast,   // is_last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [37:0] conv_value, [39:38] zero
   input  logic        rsp_tlast,   // last_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      logic signed [CONV_BITS-1:0] sum;
      logic                        final_flag;
   } conv_out_t;

   // Shadow copy of the block's state
   logic signed [SAMPLE_BITS-1:0] delay_line [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] kernel [MAX_TAPS];
   logic [CFG_BITS-1:0]           length_reg;
   conv_out_t                     sums_due [$];

   // Length register as the datapath uses it: zero means one, capped at MAX_TAPS
   function automatic int active_taps();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_TAPS) return MAX_TAPS;
      return int'(length_reg);
   endfunction

   function automatic void shift_in(input logic signed [SAMPLE_BITS-1:0] value);
      for (int j = MAX_TAPS - 1; j > 0; j--) delay_line[j] = delay_line[j-1];
      delay_line[0] = value;
   endfunction

   // Exact sum of products over the taps in use, kept to the result width
   function automatic logic signed [CONV_BITS-1:0] weighted_sum(input int n);
      longint acc;
      acc = 0;
      for (int j = 0; j < n; j++) acc += longint'(kernel[j]) * longint'(delay_line[j]);
      return acc[CONV_BITS-1:0];
   endfunction

   // One sample in; a closing sample also flushes the tail with zeros
   function automatic void convolve_sample(input logic signed [SAMPLE_BITS-1:0] value,
                                           input logic closing);
      int        n;
      conv_out_t r;
      n = active_taps();
      shift_in(value);
      r.sum        = weighted_sum(n);
      r.final_flag = closing && (n == 1);
      sums_due.push_back(r);
      if (closing) begin
         for (int t = 1; t < n; t++) begin
            shift_in('0);
            r.sum        = weighted_sum(n);
            r.final_flag = (t == n - 1);
            sums_due.push_back(r);
         end
         for (int j = 0; j < MAX_TAPS; j++) delay_line[j] = '0;
      end
   endfunction

   always @(posedge clock) begin
      conv_out_t want;
      if (reset) begin
         for (int j = 0; j < MAX_TAPS; j++) begin
            delay_line[j] = '0;
            kernel[j]     = '0;
         end
         length_reg = CFG_BITS'(1);
         sums_due.delete();
      end else begin
         // result transfer: compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (sums_due.size() == 0) begin
               mismatches++;
               $display("%0t flc_conv_checker: unexpected result, expected none, got sum %0d last %0b",
                        $time, $signed(rsp_tdata[CONV_BITS-1:0]), rsp_tlast);
            end else begin
               want = sums_due.pop_front();
               if (rsp_tdata[CONV_BITS-1:0] !== want.sum) begin
                  mismatches++;
                  $display("%0t flc_conv_checker: conv_value expected %0d got %0d",
                           $time, want.sum, $signed(rsp_tdata[CONV_BITS-1:0]));
               end
               if (rsp_tlast !== want.final_flag) begin
                  mismatches++;
                  $display("%0t flc_conv_checker: last_out expected %0b got %0b",
                           $time, want.final_flag, rsp_tlast);
               end
            end
         end
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_KERNEL_LENGTH)
            length_reg = csr_pwdata[CFG_BITS-1:0];
         // request transfer
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_KERNEL)
               kernel[req_tdata[TAP_BITS-1:0]] = req_tdata[TAP_BITS +: SAMPLE_BITS];
            else
               convolve_sample(req_tdata[TAP_BITS +: SAMPLE_BITS], req_tlast);
         end
      end
      outstanding = sums_due.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for full_linear_convolution: clock, reset, stimulus, CSR writes and verdict.
// Depends on flc_pkg, full_linear_convolution and flc_conv_checker.
`timescale 1ns / 1ps

module tb_top;
   import flc_pkg::*;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 80;    // longer than one full-length MAC pass
   localparam int STALL_CYCLES  = 400;   // long receiver hold-off
   localparam int ITEM_TARGET   = 210;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [5:0] tap_index, [21:6] sample_value, [23:22] zero
   logic        req_tuser = 1'b0; // op
   logic        req_tlast = 1'b0; // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [37:0] conv_value, [39:38] zero
   logic        rsp_tlast;        // last_out
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatches;
   int outstanding;
   int items_sent = 0;
   int cycle_count = 0;
   int taps_active = 1;
   bit tap_loaded [MAX_TAPS];
   bit send_burst = 1'b0;
   bit take_burst = 1'b0;

   full_linear_convolution dut (.*);

   flc_conv_checker conv_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Mostly uniform over the field, otherwise an edge value (8000, 7FFF, 0000 or FFFF)
   function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
      if ($urandom_range(0, 4) != 0) return SAMPLE_BITS'($urandom);
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // One request transfer; returns at the falling edge after it was taken,
   // leaving tvalid high so a back-to-back item needs no gap
   task automatic send_item(input logic op, input logic [TAP_BITS-1:0] idx,
                            input logic signed [SAMPLE_BITS-1:0] value, input logic closing);
      int gap;
      if (items_sent % 20 == 0) send_burst = ($urandom_range(0, 2) == 0);
      gap = send_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tlast  = closing;
      req_tdata  = {2'b00, value, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic load_tap(input logic [TAP_BITS-1:0] idx,
                           input logic signed [SAMPLE_BITS-1:0] value, input logic junk_last);
      send_item(OP_KERNEL, idx, value, junk_last);
      tap_loaded[idx] = 1'b1;
   endtask

   // tap_index is ignored on samples, so it carries random bits
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic closing);
      send_item(OP_SAMPLE, TAP_BITS'($urandom), value, closing);
   endtask

   // Write any tap in use that was never loaded
   task automatic fill_taps();
      for (int i = 0; i < taps_active; i++)
         if (!tap_loaded[i]) load_tap(TAP_BITS'(i), pick_value(), 1'($urandom));
   endtask

   // Length write once the block has drained, then make the taps in use valid
   task automatic set_length(input logic [CFG_BITS-1:0] value);
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {REG_KERNEL_LENGTH, 2'b00};
      csr_pwdata  = {{(32 - CFG_BITS){1'b0}}, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      taps_active = (value == 0) ? 1 : (value > MAX_TAPS) ? MAX_TAPS : int'(value);
      fill_taps();
   endtask

   // Receiver: random ready gaps, bursts of zero gap, two long hold-offs
   initial begin
      int gap;
      int holds_done;
      holds_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) take_burst = ($urandom_range(0, 1) == 0);
         gap = take_burst ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         if ((holds_done == 0 && items_sent >= 100) || (holds_done == 1 && items_sent >= 170)) begin
            holds_done++;
            rsp_tready = 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      logic [CFG_BITS-1:0] new_len;
      int                  signals;
      int                  count;
      bit                  open_end;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // short kernel with full-scale taps and samples
      set_length(CFG_BITS'(4));
      load_tap(6'd0, 16'h8000, 1'b1);
      load_tap(6'd1, 16'h7FFF, 1'b0);
      load_tap(6'd2, 16'h0000, 1'b0);
      load_tap(6'd3, 16'hFFFF, 1'b1);
      load_tap(6'd63, 16'h3039, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h0001, 1'b1);
      // single tap: the first result is also the final one
      set_length(CFG_BITS'(1));
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0005, 1'b1);
      // length zero behaves as one tap
      set_length(CFG_BITS'(0));
      send_sample(16'hFFFF, 1'b1);
      // tap rewritten in the middle of a signal
      set_length(CFG_BITS'(4));
      send_sample(16'd100, 1'b0);
      load_tap(6'd1, 16'd77, 1'b0);
      send_sample(16'd200, 1'b1);
      // length changed in the middle of a signal
      set_length(CFG_BITS'(2));
      send_sample(16'h7FFF, 1'b0);
      set_length(CFG_BITS'(3));
      send_sample(16'h8001, 1'b1);
      // over-range length saturates to the full kernel
      set_length(CFG_BITS'(127));
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      set_length(CFG_BITS'(64));
      send_sample(16'h8000, 1'b1);

      // random phases: a length, then a few signals; mostly short kernels
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 11))
            0: new_len = ($urandom_range(0, 1) == 0) ? CFG_BITS'(64)
                                                     : CFG_BITS'($urandom_range(65, 127));
            1: new_len = '0;
            2, 3: new_len = CFG_BITS'($urandom_range(9, 20));
            default: new_len = CFG_BITS'($urandom_range(1, 8));
         endcase
         set_length(new_len);
         signals = $urandom_range(1, 4);
         for (int s = 0; s < signals; s++) begin
            count = $urandom_range(1, 10);
            // now and then the last signal stays open across the next length change
            open_end = (s == signals - 1) && ($urandom_range(0, 3) == 0);
            for (int k = 0; k < count; k++) begin
               if ($urandom_range(0, 9) == 0)
                  load_tap(TAP_BITS'($urandom), pick_value(), 1'($urandom));
               send_sample(pick_value(), (k == count - 1) && !open_end);
            end
         end
      end
      send_sample(pick_value(), 1'b1);

      // drain, then settle
      req_tvalid = 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/flc_pkg.sv
hw/rtl/full_linear_convolution.sv
hw/rtl/flc_checker.sv
bench/flc_conv_checker.sv
bench/tb_top.sv
